// ===== sv/lcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpg_pkg
// Shared types, codes and the joint limit table of the chirp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpg_pkg;

  localparam int SINE_INDEX_BITS_DFLT = 10;
  localparam int PHASE_BITS_DFLT      = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int POS_W      = 16;
  localparam int INCR_W     = 32;
  localparam int MAG_W      = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_INCREMENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_SELECT    = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic [14:0]        amplitude;
    logic [30:0]        start_increment;
    logic signed [24:0] increment_step;
    logic [15:0]        sweep_ticks;
    logic [2:0]         joint_select;
  } cfg_t;

  typedef struct packed {
    logic signed [INCR_W-1:0] incr;
    logic signed [POS_W-1:0]  start_pos;
    logic                     done;
  } item_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  function automatic logic signed [POS_W-1:0] lim_lo(input logic [2:0] j);
    unique case (j)
      3'd0:    lim_lo = -16'sd9650;
      3'd1:    lim_lo = -16'sd9650;
      3'd2:    lim_lo = -16'sd3215;
      3'd3:    lim_lo = 16'sd0;
      3'd4:    lim_lo = -16'sd3215;
      3'd5:    lim_lo = 16'sd0;
      default: lim_lo = -16'sd6435;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] lim_hi(input logic [2:0] j);
    unique case (j)
      3'd0:    lim_hi = 16'sd3215;
      3'd1:    lim_hi = 16'sd0;
      3'd2:    lim_hi = 16'sd6435;
      3'd3:    lim_hi = 16'sd7148;
      3'd4:    lim_hi = 16'sd6435;
      3'd5:    lim_hi = 16'sd3215;
      default: lim_hi = 16'sd5718;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/lcpg_regs.sv =====
// ----------------------------------------------------------------------------
// lcpg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [lcpg_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [lcpg_pkg::CFG_DATA_W-1:0]    wr_data,
  output lcpg_pkg::cfg_t                          cfg
);
  import lcpg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude       <= 15'd492;
      cfg_r.start_increment <= 31'd4294967;
      cfg_r.increment_step  <= 25'sd15032;
      cfg_r.sweep_ticks     <= 16'd4000;
      cfg_r.joint_select    <= 3'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_AMPLITUDE:       cfg_r.amplitude       <= wr_data[14:0];
        CFG_START_INCREMENT: cfg_r.start_increment <= wr_data[30:0];
        CFG_INCREMENT_STEP:  cfg_r.increment_step  <= $signed(wr_data[24:0]);
        CFG_SWEEP_TICKS:     cfg_r.sweep_ticks     <= wr_data[15:0];
        CFG_JOINT_SELECT:    cfg_r.joint_select    <= wr_data[2:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/lcpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcpg_ctrl
// Sweep state, phase accumulator and the first pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpg_ctrl #(
  parameter int SINE_INDEX_BITS = lcpg_pkg::SINE_INDEX_BITS_DFLT,
  parameter int PHASE_BITS      = lcpg_pkg::PHASE_BITS_DFLT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  lcpg_pkg::cfg_t                         cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_opcode,
  input  wire logic signed [lcpg_pkg::POS_W-1:0] in_sample_position,
  output logic                                   dn_valid,
  input  wire logic                              dn_ready,
  output lcpg_pkg::item_t                        dn_item,
  output logic [SINE_INDEX_BITS+1:0]             dn_top
);
  import lcpg_pkg::*;

  localparam int TOP_W = SINE_INDEX_BITS + 2;

  logic                    have_sample_r, have_sample_nxt;
  logic                    started_r, started_nxt;
  logic                    finished_r, finished_nxt;
  logic signed [POS_W-1:0] latest_pos_r, latest_pos_nxt;
  logic signed [POS_W-1:0] start_pos_r, start_pos_nxt;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic [15:0]             tick_r, tick_nxt;
  logic [INCR_W-1:0]       incr_r, incr_nxt;

  logic                    accept;
  logic                    emit;
  item_t                   item_nxt;

  logic                    v_r;
  item_t                   item_r;
  logic [TOP_W-1:0]        top_r;

  assign in_ready = !v_r || dn_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    have_sample_nxt = have_sample_r;
    started_nxt     = started_r;
    finished_nxt    = finished_r;
    latest_pos_nxt  = latest_pos_r;
    start_pos_nxt   = start_pos_r;
    phase_nxt       = phase_r;
    tick_nxt        = tick_r;
    incr_nxt        = incr_r;
    emit            = 1'b0;
    item_nxt.incr      = '0;
    item_nxt.start_pos = start_pos_r;
    item_nxt.done      = 1'b0;
    if (accept) begin
      if (in_opcode == OP_SAMPLE) begin
        latest_pos_nxt  = in_sample_position;
        have_sample_nxt = 1'b1;
      end else if (have_sample_r) begin
        if (!started_r) begin
          start_pos_nxt = latest_pos_r;
          phase_nxt     = '0;
          tick_nxt      = '0;
          incr_nxt      = {1'b0, cfg.start_increment};
          started_nxt   = 1'b1;
        end else begin
          emit         = 1'b1;
          finished_nxt = finished_r || (tick_r >= cfg.sweep_ticks);
          if (finished_nxt) begin
            item_nxt.done = 1'b1;
          end else begin
            tick_nxt      = tick_r + 16'd1;
            incr_nxt      = incr_r + {{(INCR_W-25){cfg.increment_step[24]}},
                                      cfg.increment_step};
            phase_nxt     = phase_r + incr_nxt[PHASE_BITS-1:0];
            item_nxt.incr = $signed(incr_nxt);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_sample_r <= 1'b0;
      started_r     <= 1'b0;
      finished_r    <= 1'b0;
      latest_pos_r  <= '0;
      start_pos_r   <= '0;
      phase_r       <= '0;
      tick_r        <= '0;
      incr_r        <= '0;
      v_r           <= 1'b0;
    end else begin
      have_sample_r <= have_sample_nxt;
      started_r     <= started_nxt;
      finished_r    <= finished_nxt;
      latest_pos_r  <= latest_pos_nxt;
      start_pos_r   <= start_pos_nxt;
      phase_r       <= phase_nxt;
      tick_r        <= tick_nxt;
      incr_r        <= incr_nxt;
      if (in_ready) begin
        v_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item_r <= item_nxt;
      top_r  <= phase_nxt[PHASE_BITS-1 -: TOP_W];
    end
  end

  assign dn_valid = v_r;
  assign dn_item  = item_r;
  assign dn_top   = top_r;

endmodule

`default_nettype wire

// ===== sv/lcpg_sine.sv =====
// ----------------------------------------------------------------------------
// lcpg_sine
// Five-stage quarter-wave sine: fold, square, then Horner steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpg_sine #(
  parameter int SINE_INDEX_BITS = lcpg_pkg::SINE_INDEX_BITS_DFLT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  lcpg_pkg::item_t                    up_item,
  input  wire logic [SINE_INDEX_BITS+1:0]    up_top,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output lcpg_pkg::item_t                    dn_item,
  output lcpg_pkg::sine_t                    dn_sine
);
  import lcpg_pkg::*;

  localparam int N  = 1 << SINE_INDEX_BITS;
  localparam int SH = 16 - SINE_INDEX_BITS;

  logic [SINE_INDEX_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [SINE_INDEX_BITS:0]   k;
  logic [16:0]                x0;
  logic [33:0]                m1;
  logic [25:0]                m2;
  logic [12:0]                p1;
  logic [29:0]                m3;
  logic [15:0]                p2;
  logic [32:0]                m4;
  logic [16:0]                p3;
  logic [33:0]                m5;
  logic [16:0]                s5;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic        rdy1, rdy2, rdy3, rdy4, rdy5;
  item_t       it1_r, it2_r, it3_r, it4_r, it5_r;
  logic        n1_r, n2_r, n3_r, n4_r;
  logic [16:0] x1_r, x2_r, x3_r, x4_r;
  logic [16:0] sq1_r, sq2_r, sq3_r;
  logic [12:0] p1_r;
  logic [15:0] p2_r;
  logic [16:0] p3_r;
  sine_t       sine5_r;

  assign rdy5     = !v5_r || dn_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  assign idx  = up_top[SINE_INDEX_BITS-1:0];
  assign quad = up_top[SINE_INDEX_BITS+1:SINE_INDEX_BITS];
  assign k    = quad[0] ? ((SINE_INDEX_BITS+1)'(N) - {1'b0, idx}) : {1'b0, idx};
  assign x0   = 17'(k) << SH;
  assign m1   = {17'd0, x0} * {17'd0, x0};

  assign m2 = {9'd0, sq1_r} * 26'd307;
  assign p1 = 13'd5223 - {3'd0, m2[25:16]};

  assign m3 = {13'd0, sq2_r} * {17'd0, p1_r};
  assign p2 = 16'd42334 - {2'd0, m3[29:16]};

  assign m4 = {16'd0, sq3_r} * {17'd0, p2_r};
  assign p3 = 17'd102944 - m4[32:16];

  assign m5 = {17'd0, x4_r} * {17'd0, p3_r};
  assign s5 = m5[33:17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      it1_r <= up_item;
      n1_r  <= quad[1];
      x1_r  <= x0;
      sq1_r <= m1[32:16];
    end
    if (rdy2 && v1_r) begin
      it2_r <= it1_r;
      n2_r  <= n1_r;
      x2_r  <= x1_r;
      sq2_r <= sq1_r;
      p1_r  <= p1;
    end
    if (rdy3 && v2_r) begin
      it3_r <= it2_r;
      n3_r  <= n2_r;
      x3_r  <= x2_r;
      sq3_r <= sq2_r;
      p2_r  <= p2;
    end
    if (rdy4 && v3_r) begin
      it4_r <= it3_r;
      n4_r  <= n3_r;
      x4_r  <= x3_r;
      p3_r  <= p3;
    end
    if (rdy5 && v4_r) begin
      it5_r       <= it4_r;
      sine5_r.neg <= n4_r;
      sine5_r.mag <= (s5 > 17'd32767) ? 15'h7fff : s5[MAG_W-1:0];
    end
  end

  assign dn_valid = v5_r;
  assign dn_item  = it5_r;
  assign dn_sine  = sine5_r;

endmodule

`default_nettype wire

// ===== sv/lcpg_scale.sv =====
// ----------------------------------------------------------------------------
// lcpg_scale
// Amplitude scaling with rounding, offset by the start position, clamp to the
// joint limits, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpg_scale (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  lcpg_pkg::cfg_t                           cfg,
  input  wire logic                                up_valid,
  output logic                                     up_ready,
  input  lcpg_pkg::item_t                          up_item,
  input  lcpg_pkg::sine_t                          up_sine,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lcpg_pkg::POS_W-1:0]        out_command_position,
  output logic signed [lcpg_pkg::INCR_W-1:0]       out_current_increment,
  output logic                                     out_sweep_done
);
  import lcpg_pkg::*;

  logic [29:0]             m6;
  logic [29:0]             r6;

  logic                    v6_r;
  logic                    rdy6, rdy7;
  item_t                   it6_r;
  logic                    n6_r;
  logic [MAG_W-1:0]        d6_r;

  logic signed [16:0]      delta;
  logic signed [17:0]      sum;
  logic signed [17:0]      lo, hi;
  logic signed [POS_W-1:0] cmd_nxt;

  logic                    v7_r;
  logic signed [POS_W-1:0] cmd_r;
  logic signed [INCR_W-1:0] incr_r;
  logic                    done_r;

  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign up_ready = rdy6;

  assign m6 = {15'd0, cfg.amplitude} * {15'd0, up_sine.mag};
  assign r6 = m6 + 30'd16384;

  assign delta = n6_r ? -$signed({2'b00, d6_r}) : $signed({2'b00, d6_r});
  assign sum   = {{2{it6_r.start_pos[POS_W-1]}}, it6_r.start_pos} + 18'(delta);
  assign lo    = 18'(lim_lo(cfg.joint_select));
  assign hi    = 18'(lim_hi(cfg.joint_select));

  always_comb begin
    if (it6_r.done) begin
      cmd_nxt = it6_r.start_pos;
    end else if (sum < lo) begin
      cmd_nxt = lo[POS_W-1:0];
    end else if (sum > hi) begin
      cmd_nxt = hi[POS_W-1:0];
    end else begin
      cmd_nxt = sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy6) v6_r <= up_valid;
      if (rdy7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && up_valid) begin
      it6_r <= up_item;
      n6_r  <= up_sine.neg;
      d6_r  <= r6[29:15];
    end
    if (rdy7 && v6_r) begin
      cmd_r  <= cmd_nxt;
      incr_r <= it6_r.incr;
      done_r <= it6_r.done;
    end
  end

  assign out_valid             = v7_r;
  assign out_command_position  = cmd_r;
  assign out_current_increment = incr_r;
  assign out_sweep_done        = done_r;

endmodule

`default_nettype wire

// ===== sv/linear_chirp_position_generator.sv =====
// ----------------------------------------------------------------------------
// linear_chirp_position_generator
// Linear-chirp position command for one joint, sine from a polynomial
// quarter wave, clamped to the selected joint's limits.
//
//   channel | direction | beat contents
//   in_     | input     | opcode, sample_position
//   out_    | output    | command_position, current_increment, sweep_done
//   cfg_    | input     | register index, write data
//
// One item per cycle while the output is not stalled; a result passes the
// eight-register path ctrl, five sine stages, scale, output.
// Samples and the latching tick update state only and leave no result.
// A full stage holds while its successor holds, so bubbles close up under a
// stalled output. rst_n is synchronous; config writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_chirp_position_generator #(
  parameter int SINE_INDEX_BITS = lcpg_pkg::SINE_INDEX_BITS_DFLT,
  parameter int PHASE_BITS      = lcpg_pkg::PHASE_BITS_DFLT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_opcode,
  input  wire logic signed [lcpg_pkg::POS_W-1:0]   in_sample_position,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lcpg_pkg::POS_W-1:0]        out_command_position,
  output logic signed [lcpg_pkg::INCR_W-1:0]       out_current_increment,
  output logic                                     out_sweep_done,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lcpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lcpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lcpg_pkg::*;

  cfg_t                       cfg;
  logic                       c_valid, c_ready;
  item_t                      c_item;
  logic [SINE_INDEX_BITS+1:0] c_top;
  logic                       s_valid, s_ready;
  item_t                      s_item;
  sine_t                      s_sine;

  assign cfg_ready = 1'b1;

  lcpg_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lcpg_ctrl #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_sample_position (in_sample_position),
    .dn_valid           (c_valid),
    .dn_ready           (c_ready),
    .dn_item            (c_item),
    .dn_top             (c_top)
  );

  lcpg_sine #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_sine (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid),
    .up_ready (c_ready),
    .up_item  (c_item),
    .up_top   (c_top),
    .dn_valid (s_valid),
    .dn_ready (s_ready),
    .dn_item  (s_item),
    .dn_sine  (s_sine)
  );

  lcpg_scale u_scale (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .up_valid              (s_valid),
    .up_ready              (s_ready),
    .up_item               (s_item),
    .up_sine               (s_sine),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_command_position  (out_command_position),
    .out_current_increment (out_current_increment),
    .out_sweep_done        (out_sweep_done)
  );

endmodule

`default_nettype wire
